[rtl/core/verlet_chain_step_core_assert.svh]
// assertion macros for the verlet chain step core
// depends on nothing; included inside module bodies
`ifndef VERLET_CHAIN_STEP_CORE_ASSERT_SVH
`define VERLET_CHAIN_STEP_CORE_ASSERT_SVH

// same-cycle implication
`define VCS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VCS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/vcs_pkg.sv]
// shared types, constants and helpers for the verlet chain step core
// depends on nothing
package vcs_pkg;

  localparam int MaxPoints = 32;
  localparam int MaxLinks  = 64;
  localparam int FracBits  = 16;

  localparam int PtIdxW = $clog2(MaxPoints);
  localparam int LkIdxW = $clog2(MaxLinks);
  localparam int PtCntW = $clog2(MaxPoints + 1);
  localparam int LkCntW = $clog2(MaxLinks + 1);

  // dividend width of the unit vector divide and width of a unit component
  localparam int DivW  = 31 + FracBits;
  localparam int UnitW = FracBits + 1;

  // gravity 9.8 in fixed point, rounded half up
  localparam logic [31:0] GravityQ = 32'(((98 << FracBits) + 5) / 10);
  localparam logic [63:0] HalfLsb  = 64'(1) << (FracBits - 1);

  // beat kinds on the input side
  typedef enum logic [1:0] {
    OP_WR_POINT = 2'd0,
    OP_WR_LINK  = 2'd1,
    OP_STEP     = 2'd2,
    OP_RD_POINT = 2'd3
  } op_e;

  // configuration register indexes
  localparam logic [1:0] CFG_TIME_STEP = 2'd0;
  localparam logic [1:0] CFG_PASSES    = 2'd1;
  localparam logic [1:0] CFG_POINTS    = 2'd2;
  localparam logic [1:0] CFG_LINKS     = 2'd3;

  typedef struct packed {
    logic [4:0]  a;
    logic [4:0]  b;
    logic [30:0] len;
  } link_t;

  // clamp to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh07FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -36'sh080000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/verlet_chain_step_core.sv]
// verlet chain step core: point and link tables, integration and relaxation
// depends on vcs_pkg and verlet_chain_step_core_assert.svh
//
// channel   dir  beat contents
// s_axis    in   tuser operation; tdata slot, positions, pinned, link ends, rest length
// m_axis    out  tdata read_index, read_x, read_y, read_pinned
// cfg       in   cfg_index_i selects time_step, relax_passes, points_in_use, links_in_use
//
// a write is taken in the idle state; a read goes through S_RD into a registered
// result that waits for m_axis_tready. a step integrates the points in use, then
// runs the relaxation passes; each relaxed link mostly uses the shared shift-subtract
// unit: 32 square root steps, then 2 x 47 divide steps unless the ends coincide.
// reset clears the sequencer and loads the configuration defaults; tables hold nothing until written.
// s_axis_tready is low while a step or a read runs or a read result waits on m_axis.
module verlet_chain_step_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // slot, point_x, point_y, prior_x, prior_y, pinned, end_a, end_b, rest_length
  input  logic [175:0]  s_axis_tdata,
  // operation
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // read_index, read_x, read_y, read_pinned, zero fill
  output logic [71:0]   m_axis_tdata
);
  import vcs_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_RD     = 19'h00002,
    S_GRAV1  = 19'h00004,
    S_GRAV2  = 19'h00008,
    S_INT_RD = 19'h00010,
    S_INT_WR = 19'h00020,
    S_LK_RD  = 19'h00040,
    S_LK_CHK = 19'h00080,
    S_PA     = 19'h00100,
    S_PB     = 19'h00200,
    S_PREP   = 19'h00400,
    S_SQX    = 19'h00800,
    S_SQY    = 19'h01000,
    S_SQRT   = 19'h02000,
    S_DIV    = 19'h04000,
    S_OFFX   = 19'h08000,
    S_OFFY   = 19'h10000,
    S_WA     = 19'h20000,
    S_WB     = 19'h40000
  } state_e;

  // input beat fields
  logic [5:0]         in_slot;
  logic signed [31:0] in_px, in_py, in_qx, in_qy;
  logic               in_pin;
  logic [4:0]         in_ea, in_eb;
  logic [30:0]        in_len;
  op_e                in_op;
  logic               in_acc;

  assign in_slot = s_axis_tdata[5:0];
  assign in_px   = s_axis_tdata[37:6];
  assign in_py   = s_axis_tdata[69:38];
  assign in_qx   = s_axis_tdata[101:70];
  assign in_qy   = s_axis_tdata[133:102];
  assign in_pin  = s_axis_tdata[134];
  assign in_ea   = s_axis_tdata[139:135];
  assign in_eb   = s_axis_tdata[144:140];
  assign in_len  = s_axis_tdata[175:145];
  assign in_op   = op_e'(s_axis_tuser);

  // control registers
  state_e              state_q, state_d;
  logic [PtCntW-1:0]   idx_q, idx_d;
  logic [LkCntW-1:0]   lk_q, lk_d;
  logic [4:0]          pass_q, pass_d;
  logic [5:0]          cnt_q, cnt_d;
  logic                divy_q, divy_d;
  logic                out_valid_q, out_valid_d;
  logic [15:0]         time_step_q;
  logic [4:0]          passes_q;
  logic [5:0]          points_q;
  logic [6:0]          links_q;

  // tables
  logic signed [31:0] cur_x_mem [MaxPoints];
  logic signed [31:0] cur_y_mem [MaxPoints];
  logic signed [31:0] old_x_mem [MaxPoints];
  logic signed [31:0] old_y_mem [MaxPoints];
  logic               pin_mem   [MaxPoints];
  link_t              link_mem  [MaxLinks];

  logic [PtIdxW-1:0]  pt_raddr, pt_waddr;
  logic               we_cur, we_old, we_pin;
  logic signed [31:0] w_cx, w_cy, w_ox, w_oy;
  logic               w_pin;
  logic               lk_we;
  logic [LkIdxW-1:0]  lk_raddr;

  logic signed [31:0] rd_cx_q, rd_cy_q, rd_ox_q, rd_oy_q;
  logic               rd_pin_q;
  link_t              lk_rd_q;

  // datapath registers
  logic [31:0]        dt2_q, g_q;
  logic [4:0]         a_q, b_q;
  logic [30:0]        len_q;
  logic signed [31:0] ax_q, ay_q, bx_q, by_q, mx_q, my_q;
  logic               pa_q, pb_q, negx_q, negy_q;
  logic [30:0]        mxa_q, mya_q;
  logic [63:0]        sq_q, rem_q, res_q, aux_q;
  logic [31:0]        dist_q;
  logic [UnitW-1:0]   ux_q, uy_q;
  logic [30:0]        offx_q, offy_q;
  logic [PtIdxW-1:0]  out_idx_q, rd_slot_q;
  logic signed [31:0] out_x_q, out_y_q;
  logic               out_pin_q;

  // clamped counts
  logic [PtCntW-1:0] np;
  logic [LkCntW-1:0] nl;
  assign np = (points_q > PtCntW'(MaxPoints)) ? PtCntW'(MaxPoints) : PtCntW'(points_q);
  assign nl = (links_q > LkCntW'(MaxLinks)) ? LkCntW'(MaxLinks) : LkCntW'(links_q);

  logic slot_pt_ok, slot_lk_ok;
  assign slot_pt_ok = 32'(in_slot) < 32'(MaxPoints);
  assign slot_lk_ok = 32'(in_slot) < 32'(MaxLinks);

  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) & ~out_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_pin_q, out_y_q, out_x_q, 5'(out_idx_q)};

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_GRAV1: begin
        mul_a = 32'(time_step_q);
        mul_b = 32'(time_step_q);
      end
      S_GRAV2: begin
        mul_a = GravityQ;
        mul_b = dt2_q;
      end
      S_SQX: begin
        mul_a = 32'(mxa_q);
        mul_b = 32'(mxa_q);
      end
      S_SQY: begin
        mul_a = 32'(mya_q);
        mul_b = 32'(mya_q);
      end
      S_OFFX: begin
        mul_a = 32'(ux_q);
        mul_b = 32'(len_q);
      end
      S_OFFY: begin
        mul_a = 32'(uy_q);
        mul_b = 32'(len_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // shared shift-subtract unit: square root step and restoring divide step
  logic [63:0] sq_sum, sq_rem_nx, sq_res_nx;
  logic        sq_ge;
  logic [63:0] dv_rem_sh, dv_rem_nx, dv_res_nx;
  logic        dv_ge;
  always_comb begin
    sq_sum    = res_q + aux_q;
    sq_ge     = rem_q >= sq_sum;
    sq_rem_nx = sq_ge ? (rem_q - sq_sum) : rem_q;
    sq_res_nx = sq_ge ? ((res_q >> 1) + aux_q) : (res_q >> 1);
    dv_rem_sh = {rem_q[62:0], aux_q[DivW-1]};
    dv_ge     = dv_rem_sh >= 64'(dist_q);
    dv_rem_nx = dv_ge ? (dv_rem_sh - 64'(dist_q)) : dv_rem_sh;
    dv_res_nx = {res_q[62:0], dv_ge};
  end

  // link geometry
  logic signed [32:0] dx, dy, sx, sy;
  logic [32:0]        absx, absy;
  logic               big;
  always_comb begin
    dx   = 33'(ax_q) - 33'(bx_q);
    dy   = 33'(ay_q) - 33'(by_q);
    sx   = 33'(ax_q) + 33'(bx_q);
    sy   = 33'(ay_q) + 33'(by_q);
    absx = dx[32] ? 33'(-dx) : 33'(dx);
    absy = dy[32] ? 33'(-dy) : 33'(dy);
    big  = (absx[32:31] != 2'b00) | (absy[32:31] != 2'b00);
  end

  // new end positions
  logic signed [35:0] offx36, offy36, new_ax, new_ay, new_bx, new_by;
  always_comb begin
    offx36 = negx_q ? -$signed({5'b0, offx_q}) : $signed({5'b0, offx_q});
    offy36 = negy_q ? -$signed({5'b0, offy_q}) : $signed({5'b0, offy_q});
    new_ax = 36'(mx_q) + offx36;
    new_ay = 36'(my_q) + offy36;
    new_bx = 36'(mx_q) - offx36;
    new_by = 36'(my_q) - offy36;
  end

  // verlet integration of one point
  logic signed [35:0] int_x, int_y;
  assign int_x = 36'(rd_cx_q) + (36'(rd_cx_q) - 36'(rd_ox_q));
  assign int_y = 36'(rd_cy_q) + (36'(rd_cy_q) - 36'(rd_oy_q)) + $signed(36'(g_q));

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    lk_d        = lk_q;
    pass_d      = pass_q;
    cnt_d       = cnt_q;
    divy_d      = divy_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    pt_raddr    = idx_q[PtIdxW-1:0];
    lk_raddr    = lk_q[LkIdxW-1:0];
    pt_waddr    = idx_q[PtIdxW-1:0];
    we_cur      = 1'b0;
    we_old      = 1'b0;
    we_pin      = 1'b0;
    w_cx        = in_px;
    w_cy        = in_py;
    w_ox        = in_qx;
    w_oy        = in_qy;
    w_pin       = in_pin;
    lk_we       = 1'b0;
    case (state_q)
      S_IDLE: begin
        pt_raddr = in_slot[PtIdxW-1:0];
        if (in_acc) begin
          case (in_op)
            OP_WR_POINT: begin
              pt_waddr = in_slot[PtIdxW-1:0];
              we_cur   = slot_pt_ok;
              we_old   = slot_pt_ok;
              we_pin   = slot_pt_ok;
            end
            OP_WR_LINK: lk_we = slot_lk_ok;
            OP_STEP: begin
              state_d = S_GRAV1;
              idx_d   = '0;
              lk_d    = '0;
              pass_d  = '0;
            end
            OP_RD_POINT: begin
              if (slot_pt_ok) state_d = S_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_GRAV1: state_d = S_GRAV2;
      S_GRAV2: state_d = S_INT_RD;
      S_INT_RD: begin
        state_d = (idx_q < np) ? S_INT_WR : S_LK_RD;
      end
      S_INT_WR: begin
        we_cur  = ~rd_pin_q;
        we_old  = ~rd_pin_q;
        w_cx    = sat32(int_x);
        w_cy    = sat32(int_y);
        w_ox    = rd_cx_q;
        w_oy    = rd_cy_q;
        idx_d   = idx_q + 1'b1;
        state_d = S_INT_RD;
      end
      S_LK_RD: begin
        if (pass_q >= passes_q) begin
          state_d = S_IDLE;
        end else if (lk_q >= nl) begin
          pass_d = pass_q + 1'b1;
          lk_d   = '0;
        end else begin
          state_d = S_LK_CHK;
        end
      end
      S_LK_CHK: begin
        pt_raddr = lk_rd_q.a;
        if ((PtCntW'(lk_rd_q.a) >= np) || (PtCntW'(lk_rd_q.b) >= np)) begin
          lk_d    = lk_q + 1'b1;
          state_d = S_LK_RD;
        end else begin
          state_d = S_PA;
        end
      end
      S_PA: begin
        pt_raddr = b_q;
        state_d  = S_PB;
      end
      S_PB:   state_d = S_PREP;
      S_PREP: state_d = S_SQX;
      S_SQX:  state_d = S_SQY;
      S_SQY: begin
        cnt_d   = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'd31) begin
          cnt_d   = '0;
          divy_d  = 1'b0;
          state_d = (sq_res_nx == 64'd0) ? S_OFFX : S_DIV;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'(DivW - 1)) begin
          cnt_d = '0;
          if (!divy_q) begin
            divy_d = 1'b1;
          end else begin
            divy_d  = 1'b0;
            state_d = S_OFFX;
          end
        end
      end
      S_OFFX: state_d = S_OFFY;
      S_OFFY: state_d = S_WA;
      S_WA: begin
        pt_waddr = a_q;
        we_cur   = ~pa_q;
        w_cx     = sat32(new_ax);
        w_cy     = sat32(new_ay);
        state_d  = S_WB;
      end
      S_WB: begin
        pt_waddr = b_q;
        we_cur   = ~pb_q;
        w_cx     = sat32(new_bx);
        w_cy     = sat32(new_by);
        lk_d     = lk_q + 1'b1;
        state_d  = S_LK_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      lk_q        <= '0;
      pass_q      <= '0;
      cnt_q       <= '0;
      divy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      time_step_q <= 16'd655;
      passes_q    <= 5'd10;
      points_q    <= '0;
      links_q     <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      lk_q        <= lk_d;
      pass_q      <= pass_d;
      cnt_q       <= cnt_d;
      divy_q      <= divy_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TIME_STEP: time_step_q <= cfg_data_i;
          CFG_PASSES:    passes_q    <= cfg_data_i[4:0];
          CFG_POINTS:    points_q    <= cfg_data_i[5:0];
          CFG_LINKS:     links_q     <= cfg_data_i[6:0];
          default:       time_step_q <= time_step_q;
        endcase
      end
    end
  end

  // point table, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (we_cur) begin
      cur_x_mem[pt_waddr] <= w_cx;
      cur_y_mem[pt_waddr] <= w_cy;
    end
    if (we_old) begin
      old_x_mem[pt_waddr] <= w_ox;
      old_y_mem[pt_waddr] <= w_oy;
    end
    if (we_pin) pin_mem[pt_waddr] <= w_pin;
    rd_cx_q  <= cur_x_mem[pt_raddr];
    rd_cy_q  <= cur_y_mem[pt_raddr];
    rd_ox_q  <= old_x_mem[pt_raddr];
    rd_oy_q  <= old_y_mem[pt_raddr];
    rd_pin_q <= pin_mem[pt_raddr];
  end

  // link table
  always_ff @(posedge clk_i) begin
    if (lk_we) link_mem[in_slot[LkIdxW-1:0]] <= '{a: in_ea, b: in_eb, len: in_len};
    lk_rd_q <= link_mem[lk_raddr];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: rd_slot_q <= in_slot[PtIdxW-1:0];
      S_RD: begin
        out_idx_q <= rd_slot_q;
        out_x_q   <= rd_cx_q;
        out_y_q   <= rd_cy_q;
        out_pin_q <= rd_pin_q;
      end
      S_GRAV1: dt2_q <= 32'((mul_p + HalfLsb) >> FracBits);
      S_GRAV2: g_q   <= 32'((mul_p + HalfLsb) >> FracBits);
      S_LK_CHK: begin
        a_q   <= lk_rd_q.a;
        b_q   <= lk_rd_q.b;
        len_q <= lk_rd_q.len;
      end
      S_PA: begin
        ax_q <= rd_cx_q;
        ay_q <= rd_cy_q;
        pa_q <= rd_pin_q;
      end
      S_PB: begin
        bx_q <= rd_cx_q;
        by_q <= rd_cy_q;
        pb_q <= rd_pin_q;
      end
      S_PREP: begin
        mx_q   <= 32'(sx >>> 1);
        my_q   <= 32'(sy >>> 1);
        negx_q <= dx[32];
        negy_q <= dy[32];
        mxa_q  <= big ? absx[31:1] : absx[30:0];
        mya_q  <= big ? absy[31:1] : absy[30:0];
      end
      S_SQX: sq_q <= mul_p;
      S_SQY: begin
        rem_q <= sq_q + mul_p;
        res_q <= '0;
        aux_q <= 64'h4000_0000_0000_0000;
      end
      S_SQRT: begin
        rem_q <= sq_rem_nx;
        res_q <= sq_res_nx;
        aux_q <= aux_q >> 2;
        if (cnt_q == 6'd31) begin
          dist_q <= sq_res_nx[31:0];
          rem_q  <= '0;
          res_q  <= '0;
          aux_q  <= 64'({mxa_q, {FracBits{1'b0}}});
          ux_q   <= '0;
          uy_q   <= '0;
        end
      end
      S_DIV: begin
        rem_q <= dv_rem_nx;
        res_q <= dv_res_nx;
        aux_q <= aux_q << 1;
        if (cnt_q == 6'(DivW - 1)) begin
          if (!divy_q) begin
            ux_q  <= dv_res_nx[UnitW-1:0];
            rem_q <= '0;
            res_q <= '0;
            aux_q <= 64'({mya_q, {FracBits{1'b0}}});
          end else begin
            uy_q <= dv_res_nx[UnitW-1:0];
          end
        end
      end
      S_OFFX: offx_q <= mul_p[FracBits+31:FracBits+1];
      S_OFFY: offy_q <= mul_p[FracBits+31:FracBits+1];
      default: sq_q <= sq_q;
    endcase
  end

  // read beat taken on a valid slot
  logic rd_start;
  assign rd_start = in_acc & (in_op == OP_RD_POINT) & slot_pt_ok;

  `include "verlet_chain_step_core_assert.svh"

  `VCS_ASSERT_IMP(a_div_nonzero, clk_i, rst_ni, state_q == S_DIV, dist_q != 32'd0, "zero divisor")
  `VCS_ASSERT_NXT(a_read_seq, clk_i, rst_ni, rd_start, state_q == S_RD, "read not started")
  `VCS_ASSERT_IMP(a_pass_bound, clk_i, rst_ni, state_q == S_LK_CHK, pass_q < passes_q, "extra pass")

endmodule

[test/verlet_chain_checker.sv]
// checker for the verlet chain step core: watches cfg, s_axis and m_axis beats,
// keeps its own point and link tables and compares every read beat
// depends on vcs_pkg
module verlet_chain_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [175:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [71:0]  m_axis_tdata,
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import vcs_pkg::*;

  typedef struct packed {
    logic [4:0]         idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               pin;
  } point_read_t;

  // predicted configuration
  logic [15:0] dt_q;
  logic [4:0]  passes_q;
  logic [5:0]  npts_q;
  logic [6:0]  nlinks_q;

  // predicted tables
  logic signed [31:0] cur_x[MaxPoints];
  logic signed [31:0] cur_y[MaxPoints];
  logic signed [31:0] old_x[MaxPoints];
  logic signed [31:0] old_y[MaxPoints];
  logic               pin_tab[MaxPoints];
  logic [4:0]         lk_a[MaxLinks];
  logic [4:0]         lk_b[MaxLinks];
  logic [30:0]        lk_len[MaxLinks];

  point_read_t reads_due[$];

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // bitwise integer square root, floor
  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned res;
    longint unsigned bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (n >= res + bit_w) begin
        n = n - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // one distance constraint between points a and b
  task automatic relax_link(input int a, input int b, input longint unsigned len);
    longint ax, ay, bx, by, mx, my, dx, dy, ox, oy;
    longint unsigned mxa, mya, span, ux, uy;
    ax = cur_x[a]; ay = cur_y[a];
    bx = cur_x[b]; by = cur_y[b];
    mx = (ax + bx) >>> 1;
    my = (ay + by) >>> 1;
    dx = ax - bx;
    dy = ay - by;
    mxa = (dx < 0) ? -dx : dx;
    mya = (dy < 0) ? -dy : dy;
    if (mxa >= 64'h80000000 || mya >= 64'h80000000) begin
      mxa = mxa >> 1;
      mya = mya >> 1;
    end
    span = floor_root(mxa * mxa + mya * mya);
    ux = 0;
    uy = 0;
    if (span != 0) begin
      ux = (mxa << FracBits) / span;
      uy = (mya << FracBits) / span;
    end
    ox = longint'((ux * len) >> (FracBits + 1));
    oy = longint'((uy * len) >> (FracBits + 1));
    if (dx < 0) ox = -ox;
    if (dy < 0) oy = -oy;
    if (!pin_tab[a]) begin
      cur_x[a] = clamp32(mx + ox);
      cur_y[a] = clamp32(my + oy);
    end
    if (!pin_tab[b]) begin
      cur_x[b] = clamp32(mx - ox);
      cur_y[b] = clamp32(my - oy);
    end
  endtask

  // integration of all points, then the relaxation passes
  task automatic advance_chain();
    int np, nl;
    longint unsigned gq, dt2, grav;
    longint cx, cy;
    np = (npts_q > MaxPoints) ? MaxPoints : npts_q;
    nl = (nlinks_q > MaxLinks) ? MaxLinks : nlinks_q;
    gq = ((64'd98 << FracBits) + 5) / 10;
    dt2 = (longint'(dt_q) * longint'(dt_q) + (64'd1 << (FracBits - 1))) >> FracBits;
    grav = (gq * dt2 + (64'd1 << (FracBits - 1))) >> FracBits;
    for (int i = 0; i < np; i++) begin
      if (!pin_tab[i]) begin
        cx = cur_x[i];
        cy = cur_y[i];
        cur_x[i] = clamp32(cx + (cx - longint'(old_x[i])));
        cur_y[i] = clamp32(cy + (cy - longint'(old_y[i])) + longint'(grav));
        old_x[i] = cx[31:0];
        old_y[i] = cy[31:0];
      end
    end
    for (int p = 0; p < passes_q; p++) begin
      for (int i = 0; i < nl; i++) begin
        if (lk_a[i] < np && lk_b[i] < np) relax_link(lk_a[i], lk_b[i], lk_len[i]);
      end
    end
  endtask

  // track configuration and input beats, compare output beats
  always @(posedge clk_i or negedge rst_ni) begin
    point_read_t got, want;
    logic [5:0] slot;
    if (!rst_ni) begin
      dt_q <= 16'd655;
      passes_q <= 5'd10;
      npts_q <= '0;
      nlinks_q <= '0;
      fail_count_o <= 0;
      pending_o <= 0;
      reads_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TIME_STEP: dt_q <= cfg_data_i;
          CFG_PASSES:    passes_q <= cfg_data_i[4:0];
          CFG_POINTS:    npts_q <= cfg_data_i[5:0];
          CFG_LINKS:     nlinks_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        slot = s_axis_tdata[5:0];
        case (op_e'(s_axis_tuser))
          OP_WR_POINT: begin
            if (slot < MaxPoints) begin
              cur_x[slot[4:0]] = s_axis_tdata[37:6];
              cur_y[slot[4:0]] = s_axis_tdata[69:38];
              old_x[slot[4:0]] = s_axis_tdata[101:70];
              old_y[slot[4:0]] = s_axis_tdata[133:102];
              pin_tab[slot[4:0]] = s_axis_tdata[134];
            end
          end
          OP_WR_LINK: begin
            lk_a[slot] = s_axis_tdata[139:135];
            lk_b[slot] = s_axis_tdata[144:140];
            lk_len[slot] = s_axis_tdata[175:145];
          end
          OP_STEP: advance_chain();
          default: begin
            if (slot < MaxPoints) begin
              want.idx = slot[4:0];
              want.x = cur_x[slot[4:0]];
              want.y = cur_y[slot[4:0]];
              want.pin = pin_tab[slot[4:0]];
              reads_due = {reads_due, want};
            end
          end
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.idx = m_axis_tdata[4:0];
        got.x = m_axis_tdata[36:5];
        got.y = m_axis_tdata[68:37];
        got.pin = m_axis_tdata[69];
        if (reads_due.size() == 0) begin
          $display("%0t: unexpected read beat, expected none, actual %h", $realtime, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = reads_due.pop_front();
          if (got.idx !== want.idx || got.x !== want.x || got.y !== want.y ||
              got.pin !== want.pin) begin
            $display("%0t: read mismatch idx exp %0d act %0d, x exp %h act %h",
                     $realtime, want.idx, got.idx, want.x, got.x);
            $display("%0t: read mismatch y exp %h act %h, pinned exp %b act %b",
                     $realtime, want.y, got.y, want.pin, got.pin);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= reads_due.size();
    end
  end

endmodule

[test/testbench.sv]
// top of the verlet chain step testbench: clock, reset, stimulus and verdict
// depends on vcs_pkg, verlet_chain_step_core and verlet_chain_checker
module testbench;
  import vcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 4000000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_index_i = '0;
  logic [15:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;
  int           fail_count;
  int           pending;
  logic         calm = 1'b0;
  int           stall_left;
  int           cycles = 0;

  verlet_chain_step_core i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  verlet_chain_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #6 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver side stalls in bursts
  always @(posedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(1, 16);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [175:0] noise176();
    return 176'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
  endfunction

  function automatic logic [31:0] coord();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, 200 << FracBits) - (100 << FracBits);
  endfunction

  // one input beat, held until accepted; a random gap may come first
  task automatic send(input op_e op, input logic [175:0] d);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic put_point(input logic [5:0] slot, input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] qx, input logic [31:0] qy, input logic pin);
    logic [175:0] d;
    d = noise176();
    d[5:0] = slot;
    d[37:6] = px;
    d[69:38] = py;
    d[101:70] = qx;
    d[133:102] = qy;
    d[134] = pin;
    send(OP_WR_POINT, d);
  endtask

  task automatic put_link(input logic [5:0] slot, input logic [4:0] a, input logic [4:0] b,
                          input logic [30:0] len);
    logic [175:0] d;
    d = noise176();
    d[5:0] = slot;
    d[139:135] = a;
    d[144:140] = b;
    d[175:145] = len;
    send(OP_WR_LINK, d);
  endtask

  task automatic ask_point(input logic [5:0] slot);
    logic [175:0] d;
    d = noise176();
    d[5:0] = slot;
    send(OP_RD_POINT, d);
  endtask

  // a read beat queues behind any running step; once it is back the core is idle
  task automatic settle();
    ask_point(6'd0);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [15:0] dt, input logic [15:0] passes,
                          input logic [15:0] npts, input logic [15:0] nlinks);
    settle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_TIME_STEP;
    cfg_data_i <= dt;
    @(posedge clk_i);
    cfg_index_i <= CFG_PASSES;
    cfg_data_i <= passes;
    @(posedge clk_i);
    cfg_index_i <= CFG_POINTS;
    cfg_data_i <= npts;
    @(posedge clk_i);
    cfg_index_i <= CFG_LINKS;
    cfg_data_i <= nlinks;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_data_i <= 16'($urandom);
  endtask

  // mixed random beats: mostly table edits and reads, some steps
  task automatic random_beats(input int count);
    int pick;
    logic [30:0] len;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
        put_point(($urandom_range(0, 7) == 0) ? 6'($urandom_range(32, 63))
                                              : 6'($urandom_range(0, 31)),
                  coord(), coord(), coord(), coord(), $urandom_range(0, 3) == 0);
      end else if (pick < 55) begin
        len = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 20 << FracBits));
        put_link(6'($urandom), 5'($urandom), 5'($urandom), len);
      end else if (pick < 70) begin
        send(OP_STEP, noise176());
      end else begin
        ask_point(($urandom_range(0, 5) == 0) ? 6'($urandom_range(32, 63))
                                              : 6'($urandom_range(0, 31)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // step with nothing in use under reset settings
    send(OP_STEP, noise176());

    // fill the point table and the lower half of the link table; later steps
    // never use more links than that
    for (int i = 0; i < MaxPoints; i++) begin
      put_point(6'(i), coord(), coord(), coord(), coord(), $urandom_range(0, 3) == 0);
    end
    for (int i = 0; i < MaxLinks / 2; i++) begin
      put_link(6'(i), 5'($urandom), 5'($urandom), 31'($urandom_range(0, 20 << FracBits)));
    end

    // directed: coincident ends, same-point link, pinned end, saturation, halving
    set_regs(16'hFFFF, 16'd2, 16'd32, 16'd4);
    put_point(6'd0, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 1'b0);
    put_point(6'd1, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 1'b0);
    put_point(6'd2, 32'hFFF0_0000, 32'h0040_0000, 32'h0, 32'h0, 1'b1);
    put_point(6'd31, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    put_point(6'd40, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    put_link(6'd0, 5'd0, 5'd1, 31'h7FFF_FFFF);
    put_link(6'd1, 5'd2, 5'd2, 31'h0001_0000);
    put_link(6'd2, 5'd0, 5'd2, 31'h0);
    put_link(6'd3, 5'd31, 5'd0, 31'h0004_0000);
    ask_point(6'd31);
    send(OP_STEP, noise176());
    ask_point(6'd0);
    ask_point(6'd1);
    ask_point(6'd2);
    ask_point(6'd31);
    ask_point(6'd63);
    ask_point(6'd32);

    // counts above the table sizes and zero passes
    set_regs(16'd0, 16'd0, 16'd63, 16'd127);
    send(OP_STEP, noise176());
    ask_point(6'd5);
    ask_point(6'd30);

    // half of the link table in use with one pass
    set_regs(16'd655, 16'd1, 16'd32, 16'd32);
    random_beats(10);

    // most passes over a short chain
    set_regs(16'hFFFF, 16'd31, 16'd4, 16'd6);
    for (int i = 0; i < 6; i++) put_link(6'(i), 5'($urandom_range(0, 3)),
                                         5'($urandom_range(0, 3)),
                                         31'($urandom_range(0, 4 << FracBits)));
    send(OP_STEP, noise176());
    for (int i = 0; i < 4; i++) ask_point(6'(i));

    // random settings, small chains
    for (int ph = 0; ph < 4; ph++) begin
      set_regs(16'($urandom), 16'($urandom_range(1, 3)), 16'($urandom_range(2, 12)),
               16'($urandom_range(1, 10)));
      random_beats(6);
    end

    // last stretch without idling
    calm <= 1'b1;
    set_regs(16'd655, 16'd3, 16'd8, 16'd8);
    random_beats(10);
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
